/* rtl/dqvd_pkg.sv */
// ============================================================================
// dqvd_pkg - shared types, codes and helpers for the bounded deque
// Holds the sizing constants, command and status codes, and the ring-index
// and word-format helpers used by the core.
// ============================================================================
package dqvd_pkg;

  // Sizing
  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 32;
  localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;

  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [SUM_W-1:0]      sum_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  // Command codes
  localparam logic [3:0] CMD_AF       = 4'd0;
  localparam logic [3:0] CMD_AL       = 4'd1;
  localparam logic [3:0] CMD_DF       = 4'd2;
  localparam logic [3:0] CMD_DL       = 4'd3;
  localparam logic [3:0] CMD_CLEAR    = 4'd4;
  localparam logic [3:0] CMD_DE       = 4'd5;
  localparam logic [3:0] CMD_PRINT_A  = 4'd6;
  localparam logic [3:0] CMD_PRINT_F  = 4'd7;
  localparam logic [3:0] CMD_PRINT_L  = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Ring index of base + off, with base below CAPACITY and off at most CAPACITY
  function automatic addr_t wrap(addr_t base, cnt_t off);
    sum_t sum;
    sum = sum_t'(base) + sum_t'(off);
    if (sum >= sum_t'(CAPACITY)) begin
      sum = sum - sum_t'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  // Stored word from a 32-bit input: sign-extend, then keep WORD_WIDTH bits
  function automatic word_t to_word(logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[WORD_WIDTH-1:0];
  endfunction

  // 32-bit result field from a stored word: sign-extend, then keep 32 bits
  function automatic logic [31:0] to_elem(word_t w);
    logic [63:0] e;
    e = 64'(signed'(w));
    return e[31:0];
  endfunction

endpackage

/* rtl/dqvd_ram.sv */
// ============================================================================
// dqvd_ram - generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ============================================================================
module dqvd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/deque_with_value_delete_core.sv */
// ============================================================================
// deque_with_value_delete_core - bounded double-ended queue with value delete
// Ring store with head index and entry count, run by a small sequencer with a read
// and a write ring-index adder, one word comparator and one RAM read port.
// ============================================================================
// Sequencing: end operations, clear and empty prints pass through the execute
//   state and then raise their result. Delete-value walks the list at one entry
//   per cycle through the RAM read port, then raises its result.
// Prints step through each element in order: read address, registered RAM read,
//   then a result beat that is held until taken.
// One command at a time; the next command beat is taken after the last result.
// Reset clears head index, entry count and control; the store is not cleared.
module deque_with_value_delete_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [3:0]         cmd,
  input  logic signed [31:0] value,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [31:0] elem_value,
  output logic               has_elem,
  output logic [1:0]         status,
  output logic               last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_DWALK = 3'd2;
  localparam logic [2:0] S_PRD   = 3'd3;
  localparam logic [2:0] S_PLOAD = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]           state;
  logic [3:0]           cmd_r;
  dqvd_pkg::word_t      word_r;
  dqvd_pkg::cnt_t       n_r;
  dqvd_pkg::cnt_t       start;
  dqvd_pkg::cnt_t       idx;
  dqvd_pkg::cnt_t       keep;
  logic                 pend;
  logic                 more;
  dqvd_pkg::addr_t      head;
  dqvd_pkg::cnt_t       count;

  dqvd_pkg::cnt_t       rd_off;
  dqvd_pkg::cnt_t       wr_off;
  dqvd_pkg::addr_t      rd_slot;
  dqvd_pkg::addr_t      dec_head;
  dqvd_pkg::cnt_t       clamp_n;
  logic                 full;
  logic                 empty;
  logic                 mismatch;

  logic                 ram_we;
  dqvd_pkg::addr_t      ram_waddr;
  dqvd_pkg::word_t      ram_rdata;

  logic                 cmd_accept;
  logic                 res_accept;

  assign cmd_stall  = (state != S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_accept = res_valid && !res_stall;

  assign full     = (count == dqvd_pkg::cnt_t'(dqvd_pkg::CAPACITY));
  assign empty    = (count == '0);
  assign mismatch = (ram_rdata != word_r);
  assign dec_head = (head == '0) ? dqvd_pkg::addr_t'(dqvd_pkg::CAPACITY - 1)
                                 : head - dqvd_pkg::addr_t'(1);

  // Clamp a print count: negative or above size gives size
  assign clamp_n = (value[31] || ($unsigned(value) > 32'(count))) ? count
                                                                 : value[dqvd_pkg::CNT_W-1:0];

  // Select ring offsets for the read and write index adders
  always_comb begin
    rd_off = idx;
    wr_off = keep;
    unique case (state)
      S_EXEC:  begin
        rd_off = dqvd_pkg::cnt_t'(1);
        wr_off = count;
      end
      S_PRD:   rd_off = start + idx;
      default: begin
        rd_off = idx;
        wr_off = keep;
      end
    endcase
  end

  assign rd_slot = dqvd_pkg::wrap(head, rd_off);

  // Drive store writes: end adds and compaction
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = dqvd_pkg::wrap(head, wr_off);
    if (state == S_EXEC && !full) begin
      if (cmd_r == dqvd_pkg::CMD_AF) begin
        ram_we    = 1'b1;
        ram_waddr = dec_head;
      end else if (cmd_r == dqvd_pkg::CMD_AL) begin
        ram_we = 1'b1;
      end
    end else if (state == S_DWALK && pend && mismatch) begin
      ram_we = 1'b1;
    end
  end

  dqvd_ram #(
    .WIDTH (dqvd_pkg::WORD_WIDTH),
    .DEPTH (dqvd_pkg::CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_we && state == S_DWALK ? ram_rdata : word_r),
    .raddr (rd_slot),
    .rdata (ram_rdata)
  );

  // Sequencer and list pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
      more      <= 1'b0;
      pend      <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_accept) begin
            cmd_r  <= cmd;
            word_r <= dqvd_pkg::to_word(value);
            n_r    <= (cmd == dqvd_pkg::CMD_PRINT_A) ? count : clamp_n;
            state  <= S_EXEC;
          end
        end

        S_EXEC: begin
          // Status result by default; walks override below
          elem_value <= '0;
          has_elem   <= 1'b0;
          status     <= dqvd_pkg::ST_OK;
          last       <= 1'b1;
          more       <= 1'b0;
          res_valid  <= 1'b1;
          state      <= S_OUT;
          idx        <= '0;
          keep       <= '0;
          pend       <= 1'b0;
          case (cmd_r)
            dqvd_pkg::CMD_AF: begin
              if (full) begin
                status <= dqvd_pkg::ST_FULL;
              end else begin
                head  <= dec_head;
                count <= count + dqvd_pkg::cnt_t'(1);
              end
            end
            dqvd_pkg::CMD_AL: begin
              if (full) begin
                status <= dqvd_pkg::ST_FULL;
              end else begin
                count <= count + dqvd_pkg::cnt_t'(1);
              end
            end
            dqvd_pkg::CMD_DF: begin
              if (empty) begin
                status <= dqvd_pkg::ST_EMPTY;
              end else begin
                head  <= rd_slot;
                count <= count - dqvd_pkg::cnt_t'(1);
              end
            end
            dqvd_pkg::CMD_DL: begin
              if (empty) begin
                status <= dqvd_pkg::ST_EMPTY;
              end else begin
                count <= count - dqvd_pkg::cnt_t'(1);
              end
            end
            dqvd_pkg::CMD_CLEAR: begin
              count <= '0;
            end
            dqvd_pkg::CMD_DE: begin
              if (empty) begin
                status <= dqvd_pkg::ST_EMPTY;
              end else begin
                res_valid <= 1'b0;
                state     <= S_DWALK;
              end
            end
            dqvd_pkg::CMD_PRINT_A, dqvd_pkg::CMD_PRINT_F, dqvd_pkg::CMD_PRINT_L: begin
              if (n_r != '0) begin
                res_valid <= 1'b0;
                start     <= (cmd_r == dqvd_pkg::CMD_PRINT_L) ? count - n_r : '0;
                state     <= S_PRD;
              end
            end
            default: begin
              // Unknown command: drop without a result
              res_valid <= 1'b0;
              state     <= S_IDLE;
            end
          endcase
        end

        S_DWALK: begin
          // Issue the next read, compare the word read last cycle
          if (idx != count) begin
            idx  <= idx + dqvd_pkg::cnt_t'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
          end
          if (pend && mismatch) begin
            keep <= keep + dqvd_pkg::cnt_t'(1);
          end
          if (idx == count && !pend) begin
            count      <= keep;
            elem_value <= '0;
            has_elem   <= 1'b0;
            status     <= dqvd_pkg::ST_OK;
            last       <= 1'b1;
            more       <= 1'b0;
            res_valid  <= 1'b1;
            state      <= S_OUT;
          end
        end

        S_PRD: begin
          state <= S_PLOAD;
        end

        S_PLOAD: begin
          // Load one printed element
          elem_value <= dqvd_pkg::to_elem(ram_rdata);
          has_elem   <= 1'b1;
          status     <= dqvd_pkg::ST_OK;
          last       <= (idx + dqvd_pkg::cnt_t'(1) == n_r);
          more       <= (idx + dqvd_pkg::cnt_t'(1) != n_r);
          idx        <= idx + dqvd_pkg::cnt_t'(1);
          res_valid  <= 1'b1;
          state      <= S_OUT;
        end

        S_OUT: begin
          // Hold the beat until taken, then advance
          if (res_accept) begin
            res_valid <= 1'b0;
            state     <= more ? S_PRD : S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= dqvd_pkg::cnt_t'(dqvd_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (state == S_OUT))
    else $error("result beat outside output state");

  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWALK) |-> (keep <= idx))
    else $error("compaction write ahead of read");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_accept && last) |=> (state == S_IDLE))
    else $error("command continued after last beat");

endmodule
